// ----- design/bitmap_page_frame_allocator_core_macros.svh -----
// ----------------------------------------------------------------------------
// Bitmap page frame allocator - assertion macros
// Concurrent check wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTH
`define BPFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpfa: assertion failed");
`define BPFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpfa: assertion failed");
`else
`define BPFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BPFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/bpfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page frame allocator - package
// Codes, field widths, shared types and bit-search helpers.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int ADDR_W      = 64;
    localparam int PIDX_W      = 16;
    localparam int COUNT_W     = 17;
    localparam int ACT_W       = 11;
    localparam int WORD_BITS   = 64;
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;

    localparam logic [ACT_W-1:0] ACT_WORDS_RESET = 11'd1024;

    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_status;
    typedef logic [0:0] t_cfg_idx;

    localparam t_kind K_ALLOC   = 2'd0;
    localparam t_kind K_FREE    = 2'd1;
    localparam t_kind K_RESERVE = 2'd2;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_NO_MEM = 2'd1;
    localparam t_status ST_RANGE  = 2'd2;

    localparam t_cfg_idx CFG_ACTIVE_WORDS = 1'b0;
    localparam t_cfg_idx CFG_ADDR_OFFSET  = 1'b1;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

    // lowest byte of a word that holds a clear bit
    function automatic logic [2:0] first_open_byte(input logic [WORD_BITS-1:0] w);
        logic [2:0] g;
        g = '0;
        for (int i = 7; i >= 0; i--) begin
            if (w[i*8 +: 8] != 8'hFF) begin
                g = 3'(i);
            end
        end
        return g;
    endfunction

    function automatic logic [2:0] lowest_zero8(input logic [7:0] b);
        logic [2:0] p;
        p = '0;
        for (int i = 7; i >= 0; i--) begin
            if (!b[i]) begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

endpackage

// ----- design/bitmap_page_frame_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page frame allocator - top level
// Next-fit page allocator over a bitmap of 64-bit words, one bit per page.
//
//  channel   signals                                   transfer
//  -------   ---------------------------------------   -------------------------
//  command   i_start, o_busy, i_kind, i_address        i_start & !o_busy
//  result    o_valid, o_page_address, o_page_index,    o_valid (one cycle)
//            o_status, o_free_pages
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,    i_cfg_valid & o_cfg_ready
//            i_cfg_data
//
//  Allocate: words are read one per cycle from the last allocation word,
//  bound by the single read port. Free/reserve: subtract, read, then
//  modify-write; a page outside the range ends before the read. After
//  reset the bitmap is filled with ones with o_busy high; config writes
//  are taken throughout. Results cannot stall.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_core #(
    parameter int BITMAP_WORDS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  bpfa_pkg::t_kind               i_kind,
    input  logic [bpfa_pkg::ADDR_W-1:0]   i_address,
    output logic                          o_valid,
    output logic [bpfa_pkg::ADDR_W-1:0]   o_page_address,
    output logic [bpfa_pkg::PIDX_W-1:0]   o_page_index,
    output bpfa_pkg::t_status             o_status,
    output logic [bpfa_pkg::COUNT_W-1:0]  o_free_pages,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  bpfa_pkg::t_cfg_idx            i_cfg_index,
    input  logic [bpfa_pkg::ADDR_W-1:0]   i_cfg_data
);
    import bpfa_pkg::*;

    localparam int WORD_AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int NW      = $clog2(BITMAP_WORDS + 1);
    localparam int CW      = (NW > ACT_W) ? NW : ACT_W;
    localparam int PW      = NW + 6;
    localparam int PGW     = WORD_AW + 6;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_GRP   = 3'd2;
    localparam logic [2:0] S_BIT   = 3'd3;
    localparam logic [2:0] S_AWR   = 3'd4;
    localparam logic [2:0] S_PCALC = 3'd5;
    localparam logic [2:0] S_PCHK  = 3'd6;
    localparam logic [2:0] S_PMOD  = 3'd7;

    // control
    logic [2:0]            r_state, n_state;
    logic                  r_o_valid;
    logic [COUNT_W-1:0]    r_free_count, n_free_count;
    logic [WORD_AW-1:0]    r_scan_start;
    logic [ACT_W-1:0]      r_active_words;
    logic [ADDR_W-1:0]     r_offset;
    logic                  r_rd_pend;

    // datapath
    t_kind                 r_kind;
    logic [ADDR_W-1:0]     r_addr;
    logic [PAGE_NUM_W-1:0] r_page;
    logic [WORD_AW-1:0]    r_scan_addr;
    logic [WORD_AW-1:0]    r_chk_addr;
    logic [WORD_AW-1:0]    r_hit_addr;
    logic [NW-1:0]         r_issued;
    logic [WORD_BITS-1:0]  r_word;
    logic [2:0]            r_grp;
    logic [5:0]            r_bit;
    logic [ADDR_W-1:0]     r_o_page_address;
    logic [PIDX_W-1:0]     r_o_page_index;
    t_status               r_o_status;

    logic                  accept;
    logic [CW-1:0]         act_ext;
    logic [NW-1:0]         words_use;
    logic [WORD_AW-1:0]    last_word;
    logic [WORD_AW-1:0]    scan_first;
    logic                  scan_issue;
    logic                  scan_hit;
    logic                  scan_done;
    logic [ADDR_W-1:0]     page_diff;
    logic                  page_in_range;
    logic [WORD_AW-1:0]    page_word;
    logic [WORD_BITS-1:0]  page_mask;
    logic                  page_used;
    logic                  page_change;
    logic [WORD_BITS-1:0]  page_new;
    logic [PGW-1:0]        hit_page;

    logic                  res_valid;
    logic [ADDR_W-1:0]     res_pa;
    logic [PIDX_W-1:0]     res_pidx;
    t_status               res_status;

    t_mem_ctl              mem_ctl;
    logic [WORD_AW-1:0]    mem_rd_addr;
    logic [WORD_AW-1:0]    mem_wr_addr;
    logic [WORD_BITS-1:0]  mem_wr_data;
    logic [WORD_BITS-1:0]  mem_rd_data;
    logic                  mem_ready;

    bpfa_bitmap_mem #(
        .WORDS (BITMAP_WORDS),
        .AW    (WORD_AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_addr (mem_rd_addr),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data),
        .o_ready   (mem_ready)
    );

    assign o_busy      = (r_state != S_IDLE) || !mem_ready;
    assign accept      = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;

    // words in use, clamped to the store depth
    assign act_ext   = CW'(r_active_words);
    assign words_use = (act_ext > CW'(BITMAP_WORDS)) ? NW'(BITMAP_WORDS) : NW'(act_ext);
    assign last_word = WORD_AW'(words_use - NW'(1));
    assign scan_first = (CW'(r_scan_start) < CW'(words_use)) ? r_scan_start : '0;

    assign scan_issue = (r_issued != words_use);
    assign scan_hit   = r_rd_pend && (mem_rd_data != '1);
    assign scan_done  = !scan_issue && !r_rd_pend;

    assign page_diff     = r_addr - r_offset;
    assign page_in_range = (r_page[PAGE_NUM_W-1:PW] == '0)
                        && (r_page[PW-1:0] < {words_use, 6'b0});
    assign page_word     = r_page[6 +: WORD_AW];
    assign page_mask     = WORD_BITS'(1) << r_page[5:0];
    assign page_used     = mem_rd_data[r_page[5:0]];
    assign page_change   = (r_kind == K_FREE) ? page_used : !page_used;
    assign page_new      = (r_kind == K_FREE) ? (mem_rd_data & ~page_mask)
                                              : (mem_rd_data | page_mask);
    assign hit_page      = {r_hit_addr, r_bit};

    always_comb begin
        n_state      = r_state;
        n_free_count = r_free_count;
        mem_ctl      = '0;
        mem_rd_addr  = r_scan_addr;
        mem_wr_addr  = r_hit_addr;
        mem_wr_data  = r_word | (WORD_BITS'(1) << r_bit);
        res_valid    = 1'b0;
        res_pa       = '0;
        res_pidx     = '0;
        res_status   = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        K_ALLOC: begin
                            if (words_use == '0) begin
                                res_valid  = 1'b1;
                                res_status = ST_NO_MEM;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        K_FREE, K_RESERVE: begin
                            n_state = S_PCALC;
                        end
                        default: begin
                            res_valid  = 1'b1;
                            res_status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                mem_ctl.rd = scan_issue;
                if (scan_hit) begin
                    n_state = S_GRP;
                end else if (scan_done) begin
                    n_state    = S_IDLE;
                    res_valid  = 1'b1;
                    res_status = ST_NO_MEM;
                end
            end
            S_GRP: begin
                n_state = S_BIT;
            end
            S_BIT: begin
                n_state = S_AWR;
            end
            S_AWR: begin
                mem_ctl.wr   = 1'b1;
                n_free_count = r_free_count - 1'b1;
                n_state      = S_IDLE;
                res_valid    = 1'b1;
                res_pa       = r_offset + (ADDR_W'(hit_page) << PAGE_SHIFT);
                res_pidx     = PIDX_W'(hit_page);
            end
            S_PCALC: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                res_pidx = r_page[PIDX_W-1:0];
                if (page_in_range) begin
                    mem_ctl.rd  = 1'b1;
                    mem_rd_addr = page_word;
                    n_state     = S_PMOD;
                end else begin
                    n_state    = S_IDLE;
                    res_valid  = 1'b1;
                    res_status = ST_RANGE;
                end
            end
            S_PMOD: begin
                mem_ctl.wr  = page_change;
                mem_wr_addr = page_word;
                mem_wr_data = page_new;
                if (page_change) begin
                    n_free_count = (r_kind == K_FREE) ? r_free_count + 1'b1
                                                      : r_free_count - 1'b1;
                end
                n_state   = S_IDLE;
                res_valid = 1'b1;
                res_pidx  = r_page[PIDX_W-1:0];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_o_valid      <= 1'b0;
            r_free_count   <= '0;
            r_scan_start   <= '0;
            r_active_words <= ACT_WORDS_RESET;
            r_offset       <= '0;
            r_rd_pend      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_o_valid    <= res_valid;
            r_free_count <= n_free_count;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ACTIVE_WORDS: r_active_words <= i_cfg_data[ACT_W-1:0];
                    CFG_ADDR_OFFSET:  r_offset       <= i_cfg_data;
                endcase
            end
            if (accept) begin
                r_rd_pend <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_rd_pend <= scan_issue;
            end
            if (r_state == S_AWR) begin
                r_scan_start <= r_hit_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind      <= i_kind;
            r_addr      <= i_address;
            r_scan_addr <= scan_first;
            r_issued    <= '0;
        end
        if (r_state == S_SCAN) begin
            if (scan_issue) begin
                r_scan_addr <= (r_scan_addr == last_word) ? '0 : r_scan_addr + 1'b1;
                r_issued    <= r_issued + 1'b1;
                r_chk_addr  <= r_scan_addr;
            end
            if (scan_hit) begin
                r_hit_addr <= r_chk_addr;
                r_word     <= mem_rd_data;
            end
        end
        if (r_state == S_GRP) begin
            r_grp <= first_open_byte(r_word);
        end
        if (r_state == S_BIT) begin
            r_bit <= {r_grp, lowest_zero8(r_word[{r_grp, 3'b000} +: 8])};
        end
        if (r_state == S_PCALC) begin
            r_page <= page_diff[ADDR_W-1:PAGE_SHIFT];
        end
        if (res_valid) begin
            r_o_page_address <= res_pa;
            r_o_page_index   <= res_pidx;
            r_o_status       <= res_status;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_page_address = r_o_page_address;
    assign o_page_index   = r_o_page_index;
    assign o_status       = r_o_status;
    assign o_free_pages   = r_free_count;

`include "bitmap_page_frame_allocator_core_macros.svh"

    `BPFA_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, mem_ctl.rd, !mem_ctl.wr)
    `BPFA_ASSERT_IMP(a_quiet_fill, i_clk, i_rst_n, !mem_ready, !o_valid && o_busy)
    `BPFA_ASSERT_IMP(a_cnt_step, i_clk, i_rst_n, r_free_count != $past(r_free_count), o_valid)
    `BPFA_ASSERT_NXT(a_alloc_reports_ok, i_clk, i_rst_n, r_state == S_AWR, o_valid && o_status == ST_OK)

endmodule

// ----- design/bpfa_bitmap_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page frame allocator - bitmap store
// Synchronous RAM with one read port and one write port, registered read,
// with a fill-to-ones sweep after reset (one word per cycle).
// ----------------------------------------------------------------------------
module bpfa_bitmap_mem #(
    parameter int WORDS = 1024,
    parameter int AW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpfa_pkg::t_mem_ctl         i_ctl,
    input  logic [AW-1:0]              i_rd_addr,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [bpfa_pkg::WORD_BITS-1:0] i_wr_data,
    output logic [bpfa_pkg::WORD_BITS-1:0] o_rd_data,
    output logic                       o_ready
);
    import bpfa_pkg::*;

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic [AW-1:0]        r_clr_addr;
    logic                 r_clr_busy;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // sweep owns the write port until every word reads as used
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '1;
        end else begin
            wr_en   = i_ctl.wr;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clr_busy;

endmodule
